// ===== hdl/dtq_pkg.sv =====
// shared types and constants of the deadline-sorted timer queue
// no dependencies; used by the controller, the datapath, the top level and the testbench
`default_nettype none

package dtq_pkg;

  // result kinds
  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_TOO_LATE = 3'd1;
  localparam logic [2:0] KIND_FULL     = 3'd2;
  localparam logic [2:0] KIND_FIRED    = 3'd3;
  localparam logic [2:0] KIND_DONE     = 3'd4;

  // request operations
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // one stored timer entry
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  handler;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic       req_load;
    logic       idx_zero_ld;
    logic       idx_count_ld;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_en;
    logic       rd_prev;
    logic       wr_shift;
    logic       wr_new;
    logic       count_inc;
    logic       count_set;
    logic       uptime_inc;
    logic       out_load;
    logic [2:0] out_kind;
    logic       out_fire;
    logic       out_last;
  } dtq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op;
    logic too_late;
    logic full;
    logic idx_zero;
    logic idx_at_count;
    logic rd_le;
    logic rd_eq;
    logic rd_lt;
    logic out_free;
  } dtq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dtq_ifs.sv =====
// request and result channel interfaces of the timer queue
// depends on nothing but the clocking of the instantiating level
`default_nettype none

interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] deadline;
  logic [7:0]  handler_id;

  modport source (output valid, output op, output deadline, output handler_id, input ready);
  modport sink   (input valid, input op, input deadline, input handler_id, output ready);
endinterface

interface dtq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  fired_id;
  logic [31:0] time_now;
  logic        last;

  modport source (output valid, output kind, output fired_id, output time_now, output last,
                  input ready);
  modport sink   (input valid, input kind, input fired_id, input time_now, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dtq_ctrl.sv =====
// controller state machine of the timer queue: sequences insert shifts and tick walks
// depends on dtq_pkg for the command, status and result kind codes
`default_nettype none

module dtq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dtq_pkg::dtq_stat_t stat,
  output dtq_pkg::dtq_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECIDE   = 8'b0000_0010,
    S_SH_CHECK = 8'b0000_0100,
    S_SH_EVAL  = 8'b0000_1000,
    S_INSERT   = 8'b0001_0000,
    S_TK_CHECK = 8'b0010_0000,
    S_TK_EVAL  = 8'b0100_0000,
    S_TK_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.op == dtq_pkg::OP_TICK) begin
          cmd.idx_zero_ld = 1'b1;
          state_next      = S_TK_CHECK;
        end else if (stat.too_late || stat.full) begin
          // refused request, queue unchanged
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = stat.too_late ? dtq_pkg::KIND_TOO_LATE : dtq_pkg::KIND_FULL;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.idx_count_ld = 1'b1;
          state_next       = S_SH_CHECK;
        end
      end
      S_SH_CHECK: begin
        if (stat.idx_zero) begin
          state_next = S_INSERT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next  = S_SH_EVAL;
        end
      end
      S_SH_EVAL: begin
        // move an entry at or below the new deadline one place down
        if (stat.rd_le) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          state_next   = S_SH_CHECK;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        if (stat.out_free) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_kind  = dtq_pkg::KIND_ACCEPTED;
          cmd.out_last  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_TK_CHECK: begin
        if (stat.idx_at_count) begin
          state_next = S_TK_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_TK_EVAL;
        end
      end
      S_TK_EVAL: begin
        // fire on equal, stop on earlier, skip on later
        if (stat.rd_eq) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = dtq_pkg::KIND_FIRED;
            cmd.out_fire = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_next   = S_TK_CHECK;
          end
        end else if (stat.rd_lt) begin
          state_next = S_TK_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_TK_CHECK;
        end
      end
      S_TK_DONE: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = dtq_pkg::KIND_DONE;
          cmd.out_last   = 1'b1;
          cmd.count_set  = 1'b1;
          cmd.uptime_inc = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/dtq_dpath.sv =====
// datapath of the timer queue: entry memory, uptime, count, walk index and result register
// depends on dtq_pkg and the channel interfaces in dtq_ifs
`default_nettype none

module dtq_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  dtq_in_if.sink                 request,
  dtq_out_if.source              result,
  input  wire dtq_pkg::dtq_cmd_t cmd,
  output dtq_pkg::dtq_stat_t     stat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  dtq_pkg::entry_t mem [DEPTH];
  dtq_pkg::entry_t rd_q;

  logic          req_op;
  logic [31:0]   req_deadline;
  logic [7:0]    req_handler;
  logic [31:0]   uptime;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_prev;
  logic [AW-1:0] rd_addr;
  logic          out_valid;

  // latched request
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_op       <= request.op;
      req_deadline <= request.deadline;
      req_handler  <= request.handler_id;
    end
  end

  // uptime and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      uptime <= '0;
      count  <= '0;
    end else begin
      if (cmd.uptime_inc) begin
        uptime <= uptime + 32'd1;
      end
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_set) begin
        count <= idx;
      end
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    priority if (cmd.idx_zero_ld) begin
      idx <= '0;
    end else if (cmd.idx_count_ld) begin
      idx <= count;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx_prev;
    end
  end

  assign idx_prev = idx - CW'(1);
  assign rd_addr  = cmd.rd_prev ? idx_prev[AW-1:0] : idx[AW-1:0];

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_shift) begin
      mem[idx[AW-1:0]] <= rd_q;
    end else if (cmd.wr_new) begin
      mem[idx[AW-1:0]] <= '{deadline: req_deadline, handler: req_handler};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.kind     <= cmd.out_kind;
      result.fired_id <= cmd.out_fire ? rd_q.handler : 8'd0;
      result.time_now <= uptime;
      result.last     <= cmd.out_last;
    end
  end

  assign result.valid = out_valid;

  // status back to the controller
  always_comb begin
    stat.op           = req_op;
    stat.too_late     = req_deadline < uptime;
    stat.full         = count == CW'(DEPTH);
    stat.idx_zero     = idx == '0;
    stat.idx_at_count = idx == count;
    stat.rd_le        = rd_q.deadline <= req_deadline;
    stat.rd_eq        = rd_q.deadline == uptime;
    stat.rd_lt        = rd_q.deadline < uptime;
    stat.out_free     = !out_valid || result.ready;
  end

endmodule

`default_nettype wire

// ===== hdl/deadline_sorted_timer_queue_core.sv =====
// top level of the deadline-sorted timer queue: controller plus datapath
// depends on dtq_pkg, dtq_ifs, dtq_ctrl and dtq_dpath
//
//   channel   direction  payload                              handshake
//   request   sink       op, deadline, handler_id             valid / ready
//   result    source     kind, fired_id, time_now, last       valid / ready
//
// a refused register request is answered from the decide state; an accepted one reads and
// shifts down each entry at or below its deadline, then writes the new entry in the gap;
// a tick reads each entry from the latest on, firing on an equal deadline, and stops at an
// earlier deadline or the end; each entry passes the single read port and its registered read.
// reset clears uptime, entry count, controller state and result valid; the memory is not cleared.
// a result stalled in the output register holds the walk until it is taken.
`default_nettype none

module deadline_sorted_timer_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  dtq_in_if.sink    request,
  dtq_out_if.source result
);

  dtq_pkg::dtq_cmd_t  cmd;
  dtq_pkg::dtq_stat_t stat;
  logic               in_ready;

  assign request.ready = in_ready;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

`default_nettype wire

// ===== tb/deadline_sorted_timer_queue_core_tb.sv =====
// self-checking testbench of the deadline-sorted timer queue core
// depends on dtq_pkg, dtq_ifs and the core; a directed table, then random requests
`timescale 1ns / 1ps

module deadline_sorted_timer_queue_core_tb;

  localparam int          DEPTH        = 16;
  localparam int          HALF_PERIOD  = 10;
  localparam int          RESET_CYCLES = 6;
  localparam int          RANDOM_ITEMS = 148;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 4 * DEPTH + 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int          DIR_ROWS     = 17;

  // one result as seen on the result channel
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  fired_id;
    logic [31:0] time_now;
    logic        last;
  } timer_result_t;

  // one row of the directed table; a typed row carries its own single result
  typedef struct {
    logic        op;
    logic [31:0] deadline;
    logic [7:0]  handler_id;
    int          reps;
    bit          typed;
    logic [2:0]  t_kind;
    logic [31:0] t_time;
  } stim_row_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtq_in_if  req_if ();
  dtq_out_if res_if ();

  deadline_sorted_timer_queue_core #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_if),
    .result (res_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // shadow copy of the queue state
  logic [31:0]      shadow_uptime;
  dtq_pkg::entry_t  shadow_entries [DEPTH+1];
  int               shadow_count;

  timer_result_t step_results[$];
  timer_result_t pending_results[$];
  int            errors       = 0;
  bit            random_phase = 1'b0;
  int unsigned   cycle_count  = 0;
  int            burst_left   = 0;
  stim_row_t     directed_rows [DIR_ROWS];

  function automatic timer_result_t make_result(logic [2:0] kind, logic [7:0] id,
                                                logic [31:0] now, logic last);
    timer_result_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.time_now = now;
    r.last     = last;
    return r;
  endfunction

  // results of one request, worked out on the shadow state
  function automatic void predict_timer_results(logic op, logic [31:0] dl, logic [7:0] hid);
    int n;
    int pos;
    bit stop;
    step_results.delete();
    n    = shadow_count;
    pos  = n;
    stop = 1'b0;
    if (op == dtq_pkg::OP_REGISTER) begin
      if (dl < shadow_uptime) begin
        step_results.push_back(make_result(dtq_pkg::KIND_TOO_LATE, 8'h00, shadow_uptime,
                                           1'b1));
      end else if (n >= DEPTH) begin
        step_results.push_back(make_result(dtq_pkg::KIND_FULL, 8'h00, shadow_uptime, 1'b1));
      end else begin
        // insert before the first entry at or below the new deadline
        for (int i = 0; i < n; i++) begin
          if (!stop && shadow_entries[i].deadline <= dl) begin
            pos  = i;
            stop = 1'b1;
          end
        end
        for (int i = n; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos].deadline = dl;
        shadow_entries[pos].handler  = hid;
        shadow_count = n + 1;
        step_results.push_back(make_result(dtq_pkg::KIND_ACCEPTED, 8'h00, shadow_uptime,
                                           1'b1));
      end
    end else begin
      // walk latest to earliest, fire on equal, cut at the first earlier deadline
      for (int i = 0; i < n; i++) begin
        if (!stop) begin
          if (shadow_entries[i].deadline == shadow_uptime) begin
            step_results.push_back(make_result(dtq_pkg::KIND_FIRED, shadow_entries[i].handler,
                                               shadow_uptime, 1'b0));
          end else if (shadow_entries[i].deadline < shadow_uptime) begin
            pos  = i;
            stop = 1'b1;
          end
        end
      end
      shadow_count = pos;
      step_results.push_back(make_result(dtq_pkg::KIND_DONE, 8'h00, shadow_uptime, 1'b1));
      shadow_uptime = shadow_uptime + 32'd1;
    end
  endfunction

  // offer one request, wait for the handshake, then book its results
  task automatic send_request(logic op, logic [31:0] dl, logic [7:0] hid,
                              bit typed, logic [2:0] t_kind, logic [31:0] t_time);
    int gap;
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.deadline   <= dl;
    req_if.handler_id <= hid;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_timer_results(op, dl, hid);
    if (typed) begin
      pending_results.push_back(make_result(t_kind, 8'h00, t_time, 1'b1));
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    // bursts of back-to-back requests with idle gaps between them
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // receiver: changing stall patterns, with one long hold-off once the random part starts
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    bit       hold_done;
    int       beat;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    beat      = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      beat++;
      if (random_phase && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   res_if.ready <= 1'b1;
          RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
          default:   res_if.ready <= (beat % 5) != 0;
        endcase
      end
    end
  end

  // result checker against the oldest booked result
  always @(posedge clk) begin
    timer_result_t want;
    timer_result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = make_result(res_if.kind, res_if.fired_id, res_if.time_now, res_if.last);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing booked: kind %0d id %02h time %08h last %0b",
                 $time, got.kind, got.fired_id, got.time_now, got.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
            got.time_now !== want.time_now || got.last !== want.last) begin
          $display({"%0t: mismatch: expected kind %0d id %02h time %08h last %0b, ",
                    "got kind %0d id %02h time %08h last %0b"},
                   $time, want.kind, want.fired_id, want.time_now, want.last,
                   got.kind, got.fired_id, got.time_now, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic        r_op;
    logic [31:0] r_dl;
    logic [7:0]  r_hid;
    int          pick;

    req_if.valid      = 1'b0;
    req_if.op         = dtq_pkg::OP_REGISTER;
    req_if.deadline   = 32'h0;
    req_if.handler_id = 8'h00;
    shadow_uptime     = 32'h0;
    shadow_count      = 0;

    // directed table: entry at uptime zero, ties, fire and drop, full queue, too late
    directed_rows = '{
      '{dtq_pkg::OP_REGISTER, 32'h0000_0000, 8'h00, 1,  1'b1, dtq_pkg::KIND_ACCEPTED, 32'd0},
      '{dtq_pkg::OP_TICK,     32'hFFFF_FFFF, 8'hFF, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0000, 8'h7E, 1,  1'b1, dtq_pkg::KIND_TOO_LATE, 32'd1},
      '{dtq_pkg::OP_REGISTER, 32'hFFFF_FFFF, 8'hFF, 1,  1'b1, dtq_pkg::KIND_ACCEPTED, 32'd1},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0003, 8'h00, 1,  1'b1, dtq_pkg::KIND_ACCEPTED, 32'd1},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0003, 8'hA5, 1,  1'b1, dtq_pkg::KIND_ACCEPTED, 32'd1},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0002, 8'h5A, 1,  1'b1, dtq_pkg::KIND_ACCEPTED, 32'd1},
      '{dtq_pkg::OP_TICK,     32'h0000_0000, 8'h00, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_TICK,     32'h1234_5678, 8'h9C, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_TICK,     32'h0000_0000, 8'h00, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_TICK,     32'h0000_0000, 8'h00, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0006, 8'h11, 15, 1'b1, dtq_pkg::KIND_ACCEPTED, 32'd5},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0006, 8'h22, 1,  1'b1, dtq_pkg::KIND_FULL,     32'd5},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0000, 8'h33, 1,  1'b1, dtq_pkg::KIND_TOO_LATE, 32'd5},
      '{dtq_pkg::OP_TICK,     32'h0000_0000, 8'h00, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_TICK,     32'h0000_0000, 8'h00, 1,  1'b0, dtq_pkg::KIND_DONE,     32'd0},
      '{dtq_pkg::OP_REGISTER, 32'h0000_0007, 8'h3C, 1,  1'b1, dtq_pkg::KIND_FULL,     32'd7}
    };

    // reset
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        send_request(directed_rows[i].op, directed_rows[i].deadline,
                     directed_rows[i].handler_id, directed_rows[i].typed,
                     directed_rows[i].t_kind, directed_rows[i].t_time);
      end
    end
    // tick that drops the fired tail and frees the queue
    send_request(dtq_pkg::OP_TICK, 32'h0, 8'h00, 1'b0, dtq_pkg::KIND_DONE, 32'd0);

    // random part: mostly ticks and registrations just ahead of the uptime
    random_phase = 1'b1;
    repeat (RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 99);
      r_dl  = $urandom;
      r_hid = 8'($urandom_range(0, 255));
      r_op  = dtq_pkg::OP_REGISTER;
      if (pick < 40) begin
        r_op = dtq_pkg::OP_TICK;
      end else if (pick < 82) begin
        r_dl = shadow_uptime + $urandom_range(0, 10);
      end else if (pick < 96) begin
        r_dl = (shadow_uptime == 0) ? 32'h0 : $urandom_range(0, shadow_uptime - 1);
      end
      send_request(r_op, r_dl, r_hid, 1'b0, dtq_pkg::KIND_DONE, 32'd0);
    end
    @(negedge clk);
    req_if.valid <= 1'b0;

    // drain, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dtq_pkg.sv
hdl/dtq_ifs.sv
hdl/dtq_ctrl.sv
hdl/dtq_dpath.sv
hdl/deadline_sorted_timer_queue_core.sv
tb/deadline_sorted_timer_queue_core_tb.sv
